/* rtl/rtul_pkg.sv */
// Shared types and constants for the route table (update / lookup).
// No dependencies; used by rtul_cell and route_table_update_lookup.
package rtul_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned TagW       = 8;
  localparam int unsigned OpW        = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // One table entry as it moves down the chain on an insert.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [TagW-1:0]  tag;
  } entry_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             match_en;  // cells compare and register a match
    logic             apply_en;  // cells commit shift or tag rewrite
    logic             shift;     // insert at the front this cycle
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [TagW-1:0]  tag;
  } ctl_t;

endpackage

/* rtl/rtul_cell.sv */
// One slot of the route table chain: holds an entry, matches against the
// broadcast word, passes priority and found address on. Uses rtul_pkg.
module rtul_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rtul_pkg::ctl_t             ctl_i,
  input  rtul_pkg::entry_t           prev_i,    // entry of the front-side neighbor
  output rtul_pkg::entry_t           entry_o,
  input  logic                       taken_i,   // a cell in front already matched
  output logic                       taken_o,
  input  logic [rtul_pkg::AddrW-1:0] found_i,
  output logic [rtul_pkg::AddrW-1:0] found_o
);

  logic                       valid_q, valid_d;
  logic [rtul_pkg::AddrW-1:0] addr_q, addr_d;
  logic [rtul_pkg::TagW-1:0]  tag_q, tag_d;
  logic                       match_q, match_d;
  logic                       first;

  always_comb begin
    match_d = match_q;
    if (ctl_i.match_en) begin
      case (ctl_i.op)
        rtul_pkg::OP_UPDATE: match_d = valid_q && (addr_q == ctl_i.addr);
        rtul_pkg::OP_LOOKUP: match_d = valid_q && (tag_q == ctl_i.tag);
        default:             match_d = 1'b0;
      endcase
    end
  end

  // frontmost match wins
  assign first   = match_q && !taken_i;
  assign taken_o = taken_i || match_q;
  assign found_o = found_i | (first ? addr_q : '0);

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    tag_d   = tag_q;
    if (ctl_i.apply_en) begin
      if (ctl_i.shift) begin
        valid_d = prev_i.valid;
        addr_d  = prev_i.addr;
        tag_d   = prev_i.tag;
      end else if (first && ctl_i.op == rtul_pkg::OP_UPDATE) begin
        tag_d = ctl_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    tag_q  <= tag_d;
  end

  assign entry_o = '{valid: valid_q, addr: addr_q, tag: tag_q};

endmodule

/* rtl/route_table_update_lookup.sv */
// Top level of the recency-ordered route table: sequencer plus a chain of
// rtul_cell slots. Depends on rtul_pkg and rtul_cell.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-------------------------
//  command  | start, busy, opcode_i, ip_addr_i, hop_tag_i    | taken when start && !busy
//  result   | result_valid_o, hit_o, found_addr_o            | one-cycle strobe
//
// Sequence: a word passes through accept, match and apply before the next word
//   can be accepted; the result strobe is registered from apply, comes in the
//   cycle after it and overlaps the next accept. Each cell registers its match
//   in the match state; the priority chain through all cells settles in apply.
// Reset: all slots invalid, sequencer idle, no strobe pending.
// Stalls: the receiver cannot stall; busy is high only during match and apply.
module route_table_update_lookup (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rtul_pkg::OpW-1:0]   opcode_i,
  input  logic [rtul_pkg::AddrW-1:0] ip_addr_i,
  input  logic [rtul_pkg::TagW-1:0]  hop_tag_i,
  output logic                       result_valid_o,
  output logic                       hit_o,
  output logic [rtul_pkg::AddrW-1:0] found_addr_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMatch = 2'd1;
  localparam logic [1:0] StApply = 2'd2;

  logic [1:0] state_q, state_d;

  // latched command word
  rtul_pkg::op_e              op_q;
  logic [rtul_pkg::AddrW-1:0] addr_q;
  logic [rtul_pkg::TagW-1:0]  tag_q;

  logic                       res_valid_q, res_valid_d;
  logic                       hit_q;
  logic [rtul_pkg::AddrW-1:0] found_q;

  rtul_pkg::ctl_t   ctl;
  rtul_pkg::entry_t new_entry;
  rtul_pkg::entry_t entry [rtul_pkg::TableDepth];
  logic                       taken [rtul_pkg::TableDepth+1];
  logic [rtul_pkg::AddrW-1:0] found [rtul_pkg::TableDepth+1];
  logic accept;
  logic any_hit;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StMatch;
      StMatch: state_d = StApply;
      StApply: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign res_valid_d = (state_q == StApply);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= rtul_pkg::op_e'(opcode_i);
      addr_q <= ip_addr_i;
      tag_q  <= hop_tag_i;
    end
    if (state_q == StApply) begin
      hit_q   <= any_hit;
      found_q <= (op_q == rtul_pkg::OP_LOOKUP) ? found[rtul_pkg::TableDepth] : '0;
    end
  end

  // Priority chain: cell 0 is the front (newest).
  assign taken[0] = 1'b0;
  assign found[0] = '0;
  assign any_hit  = taken[rtul_pkg::TableDepth];

  // Insert on add, or on update that found no matching address.
  assign ctl.match_en = (state_q == StMatch);
  assign ctl.apply_en = (state_q == StApply);
  assign ctl.shift    = (op_q == rtul_pkg::OP_ADD) ||
                        ((op_q == rtul_pkg::OP_UPDATE) && !any_hit);
  assign ctl.op       = op_q;
  assign ctl.addr     = addr_q;
  assign ctl.tag      = tag_q;

  assign new_entry = '{valid: 1'b1, addr: addr_q, tag: tag_q};

  for (genvar i = 0; i < rtul_pkg::TableDepth; i++) begin : g_cell
    rtul_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .prev_i  ((i == 0) ? new_entry : entry[(i == 0) ? 0 : i-1]),
      .entry_o (entry[i]),
      .taken_i (taken[i]),
      .taken_o (taken[i+1]),
      .found_i (found[i]),
      .found_o (found[i+1])
    );
  end

  assign result_valid_o = res_valid_q;
  assign hit_o          = hit_q;
  assign found_addr_o   = found_q;

  // match is always followed by apply
  a_match_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMatch |=> state_q == StApply)
    else $error("match phase not followed by apply");

  // a strobe only follows an apply cycle
  a_strobe_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q) == StApply)
    else $error("result strobe without apply");

  // add never reports a hit
  a_add_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && op_q == rtul_pkg::OP_ADD |-> !hit_o)
    else $error("add reported a hit");

  // only a lookup returns a nonzero address
  a_found_lookup_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && found_addr_o != '0 |-> op_q == rtul_pkg::OP_LOOKUP && hit_o)
    else $error("nonzero address outside a lookup hit");

endmodule
